// ----- rtl/rc4_pkg.sv -----
// Shared constants for the RC4 keystream generator.
`default_nettype none

package rc4_pkg;

    localparam int PERM_SIZE    = 256;
    localparam int PERM_AW      = 8;
    localparam int KEY_DEPTH_DEF = 256;
    localparam int KEY_LEN_W    = 9;
    localparam int KEY_LEN_RST  = 16;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_LOAD     = 2'd0;
    localparam t_cmd CMD_INIT     = 2'd1;
    localparam t_cmd CMD_REMIX    = 2'd2;
    localparam t_cmd CMD_GENERATE = 2'd3;

    // word address of the only register
    localparam logic REG_KEY_LEN = 1'b0;

endpackage

`default_nettype wire

// ----- rtl/rc4_keystream_generator_top.sv -----
// RC4 keystream generator: permutation and key memories with a read-modify-write sequencer.
// Generate: states G_J, G_W1, G_W2, G_OUT, then the registered result (G_OUT holds while an
//   earlier result is still stalled); generates are paced by the single write port of the
//   permutation memory (two writes per swap).
// Load: key byte written on acceptance. Init: identity fill, then key schedule (KS_RD, KS_J,
//   KS_W1, KS_W2 per entry). Remix: schedule only. No item is accepted while a command runs.
// Synchronous active-low reset clears indices, sequencer and output valid; key_length
//   resets to 16. Memories are not cleared.
`default_nettype none

module rc4_keystream_generator_top #(
    parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input items
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [1:0]                   i_command,
    input  wire  [7:0]                   i_key_index,
    input  wire  [7:0]                   i_key_byte,
    // result items
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [7:0]                   o_keystream_byte,
    // configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [rc4_pkg::APB_AW-1:0]   paddr,
    input  wire  [rc4_pkg::APB_DW-1:0]   pwdata,
    output logic [rc4_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int KW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int AW  = rc4_pkg::PERM_AW;
    localparam int LW  = rc4_pkg::KEY_LEN_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;
    localparam logic [3:0] ST_KS_RD = 4'd2;
    localparam logic [3:0] ST_KS_J  = 4'd3;
    localparam logic [3:0] ST_KS_W1 = 4'd4;
    localparam logic [3:0] ST_KS_W2 = 4'd5;
    localparam logic [3:0] ST_G_J   = 4'd6;
    localparam logic [3:0] ST_G_W1  = 4'd7;
    localparam logic [3:0] ST_G_W2  = 4'd8;
    localparam logic [3:0] ST_G_OUT = 4'd9;

    // memories
    logic [7:0] r_perm [rc4_pkg::PERM_SIZE];
    logic [7:0] r_key  [KEY_DEPTH];

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_i, r_j, r_pos, r_acc, r_sum;
    logic [7:0]    r_si, r_sj;
    logic [KW-1:0] r_kpos;
    logic [LW-1:0] r_key_len;
    logic [7:0]    r_rd_a, r_rd_b, r_rd_k;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;

    logic          accept;
    logic          cfg_wr;
    logic [AW-1:0] rd_a_addr, rd_b_addr, wr_addr;
    logic [7:0]    wr_data;
    logic          wr_en;
    logic [AW-1:0] n_j;
    logic [LW-1:0] eff_len;
    logic          kpos_wrap;
    logic          out_free;
    logic          key_wr;

    assign accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign key_wr   = accept && (i_command == rc4_pkg::CMD_LOAD)
                      && ({1'b0, i_key_index} < LW'(KEY_DEPTH));

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == rc4_pkg::REG_KEY_LEN);
    assign prdata = (paddr[2] == rc4_pkg::REG_KEY_LEN)
                    ? {{(rc4_pkg::APB_DW-LW){1'b0}}, r_key_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= LW'(rc4_pkg::KEY_LEN_RST);
        end else if (cfg_wr) begin
            r_key_len <= pwdata[LW-1:0];
        end
    end

    // zero means one, oversize saturates to the store depth
    always_comb begin
        if (r_key_len == '0) begin
            eff_len = LW'(1);
        end else if (r_key_len > LW'(KEY_DEPTH)) begin
            eff_len = LW'(KEY_DEPTH);
        end else begin
            eff_len = r_key_len;
        end
    end

    assign kpos_wrap = ((LW'(r_kpos) + LW'(1)) >= eff_len);

    // permutation memory ports
    always_comb begin
        n_j = r_j + r_rd_a;
        if (r_state == ST_KS_J) begin
            n_j = r_acc + r_rd_a + r_rd_k;
        end
        rd_a_addr = (r_state == ST_IDLE) ? (r_i + AW'(1)) : r_pos;
        unique case (r_state)
            ST_G_W2:  rd_b_addr = r_si + r_sj;
            // keep the output slot addressed while the result waits
            ST_G_OUT: rd_b_addr = r_sum;
            default:  rd_b_addr = n_j;
        endcase
        wr_en   = 1'b1;
        wr_addr = r_pos;
        wr_data = r_pos;
        unique case (r_state)
            ST_FILL: begin
                wr_addr = r_pos;
                wr_data = r_pos;
            end
            ST_KS_W1: begin
                wr_addr = r_acc;
                wr_data = r_si;
            end
            ST_KS_W2: begin
                wr_addr = r_pos;
                wr_data = r_sj;
            end
            ST_G_W1: begin
                wr_addr = r_j;
                wr_data = r_si;
            end
            ST_G_W2: begin
                wr_addr = r_i;
                wr_data = r_sj;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_perm[wr_addr] <= wr_data;
        end
        r_rd_a <= r_perm[rd_a_addr];
        r_rd_b <= r_perm[rd_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            r_key[i_key_index[KW-1:0]] <= i_key_byte;
        end
        r_rd_k <= r_key[r_kpos];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        rc4_pkg::CMD_LOAD:     n_state = ST_IDLE;
                        rc4_pkg::CMD_INIT:     n_state = ST_FILL;
                        rc4_pkg::CMD_REMIX:    n_state = ST_KS_RD;
                        rc4_pkg::CMD_GENERATE: n_state = ST_G_J;
                        default:               n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FILL:  n_state = (r_pos == '1) ? ST_KS_RD : ST_FILL;
            ST_KS_RD: n_state = ST_KS_J;
            ST_KS_J:  n_state = ST_KS_W1;
            ST_KS_W1: n_state = ST_KS_W2;
            ST_KS_W2: n_state = (r_pos == '1) ? ST_IDLE : ST_KS_RD;
            ST_G_J:   n_state = ST_G_W1;
            ST_G_W1:  n_state = ST_G_W2;
            ST_G_W2:  n_state = ST_G_OUT;
            ST_G_OUT: n_state = out_free ? ST_IDLE : ST_G_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_pos       <= '0;
            r_acc       <= '0;
            r_kpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_pos  <= '0;
                    r_acc  <= '0;
                    r_kpos <= '0;
                    if (accept && (i_command == rc4_pkg::CMD_INIT)) begin
                        r_i <= '0;
                        r_j <= '0;
                    end else if (accept && (i_command == rc4_pkg::CMD_GENERATE)) begin
                        r_i <= r_i + AW'(1);
                    end
                end
                ST_FILL:  r_pos <= r_pos + AW'(1);
                ST_KS_J: begin
                    r_acc <= n_j;
                    r_si  <= r_rd_a;
                end
                ST_KS_W1: r_sj <= r_rd_b;
                ST_KS_W2: begin
                    r_pos  <= r_pos + AW'(1);
                    r_kpos <= kpos_wrap ? '0 : r_kpos + KW'(1);
                end
                ST_G_J: begin
                    r_j  <= n_j;
                    r_si <= r_rd_a;
                end
                ST_G_W1:  r_sj <= r_rd_b;
                ST_G_W2:  r_sum <= r_si + r_sj;
                default: ;
            endcase
            if ((r_state == ST_G_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sum slot equal to i is written in the same cycle as its read: forward the swapped value
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_G_OUT) && out_free) begin
            r_out_byte <= (r_sum == r_i) ? r_sj : r_rd_b;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_keystream_byte = r_out_byte;

`ifndef SYNTH
    a_i_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_G_J) |-> (r_i == $past(r_i) + AW'(1)))
        else $error("index one did not advance by one on generate");

    a_kpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW'(r_kpos) < eff_len))
        else $error("key position beyond key length");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_G_OUT))
        else $error("result raised outside output state");

    a_ks_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_KS_W2) && (r_pos == '1)) |=> (r_state == ST_IDLE))
        else $error("key schedule did not end after last entry");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_rc4_keystream_generator_top.sv -----
// Testbench for the RC4 keystream generator: predicts each keystream byte and checks every result.
module tb_rc4_keystream_generator_top;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 1400;     // longer than init (fill plus key schedule)
    localparam int HOLD_CYCLES   = 400;
    localparam logic [rc4_pkg::APB_AW-1:0] KEY_LEN_ADDR = {rc4_pkg::REG_KEY_LEN, 2'b00};

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    rc4_pkg::t_cmd                i_command   = rc4_pkg::CMD_LOAD;
    logic [7:0]                   i_key_index = '0;
    logic [7:0]                   i_key_byte  = '0;
    logic                         i_out_stall = 1'b0;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [rc4_pkg::APB_AW-1:0]   paddr       = '0;
    logic [rc4_pkg::APB_DW-1:0]   pwdata      = '0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic [7:0]                   o_keystream_byte;
    logic [rc4_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    // predicted cipher state
    logic [7:0]                    sbox [256];
    logic [7:0]                    key_mem [256];
    bit                            key_loaded [256];
    logic [7:0]                    ks_i = '0;
    logic [7:0]                    ks_j = '0;
    logic [rc4_pkg::KEY_LEN_W-1:0] key_len_cfg =
        (rc4_pkg::KEY_LEN_W)'(rc4_pkg::KEY_LEN_RST);

    logic [7:0]  keystream_q [$];
    logic [7:0]  want_byte;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;

    rc4_keystream_generator_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_key_index      (i_key_index),
        .i_key_byte       (i_key_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_keystream_byte (o_keystream_byte),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned sched_len();
        int unsigned n;
        n = 32'(key_len_cfg);
        if (n == 0) n = 1;
        if (n > rc4_pkg::KEY_DEPTH_DEF) n = rc4_pkg::KEY_DEPTH_DEF;
        return n;
    endfunction

    function automatic void swap_sbox(logic [7:0] a, logic [7:0] b);
        logic [7:0] t;
        t       = sbox[a];
        sbox[a] = sbox[b];
        sbox[b] = t;
    endfunction

    function automatic void key_schedule_pass();
        int unsigned n;
        logic [7:0]  acc;
        n   = sched_len();
        acc = '0;
        for (int p = 0; p < rc4_pkg::PERM_SIZE; p++) begin
            acc = acc + sbox[p] + key_mem[p % n];
            swap_sbox(8'(p), acc);
        end
    endfunction

    // advance the predicted state by one accepted item
    function automatic void rc4_apply(rc4_pkg::t_cmd cmd, logic [7:0] idx, logic [7:0] kb);
        logic [7:0] sum;
        case (cmd)
            rc4_pkg::CMD_LOAD: begin
                key_mem[idx]    = kb;
                key_loaded[idx] = 1'b1;
            end
            rc4_pkg::CMD_INIT: begin
                ks_i = '0;
                ks_j = '0;
                for (int p = 0; p < rc4_pkg::PERM_SIZE; p++) sbox[p] = 8'(p);
                key_schedule_pass();
            end
            rc4_pkg::CMD_REMIX: key_schedule_pass();
            rc4_pkg::CMD_GENERATE: begin
                ks_i = ks_i + 8'd1;
                ks_j = ks_j + sbox[ks_i];
                swap_sbox(ks_i, ks_j);
                sum  = sbox[ks_i] + sbox[ks_j];
                keystream_q.push_back(sbox[sum]);
            end
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0h, got %0h", what, exp_v, act_v);
    endfunction

    task automatic send_item(rc4_pkg::t_cmd cmd, logic [7:0] idx, logic [7:0] kb);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_key_index <= idx;
        i_key_byte  <= kb;
        do @(posedge i_clk); while (o_in_stall);
        rc4_apply(cmd, idx, kb);
    endtask

    task automatic send_generate();
        send_item(rc4_pkg::CMD_GENERATE, 8'($urandom), 8'($urandom));
    endtask

    // init or remix; the schedule must never read a key byte that was never loaded
    task automatic send_schedule(rc4_pkg::t_cmd cmd);
        for (int k = 0; k < sched_len(); k++)
            if (!key_loaded[k]) send_item(rc4_pkg::CMD_LOAD, 8'(k), 8'($urandom));
        send_item(cmd, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (keystream_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_key_len();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= KEY_LEN_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (rc4_pkg::APB_DW)'(key_len_cfg))
            note_mismatch("key_length readback", (rc4_pkg::APB_DW)'(key_len_cfg), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_key_len(logic [rc4_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_LEN_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        key_len_cfg = value[rc4_pkg::KEY_LEN_W-1:0];
        @(posedge i_clk);
        check_key_len();
    endtask

    task automatic test_directed();
        check_key_len();    // reset value
        send_item(rc4_pkg::CMD_LOAD, 8'd0, 8'h00);
        send_item(rc4_pkg::CMD_LOAD, 8'd255, 8'hFF);
        send_item(rc4_pkg::CMD_LOAD, 8'd15, 8'hFF);
        for (int k = 1; k < 15; k++) send_item(rc4_pkg::CMD_LOAD, 8'(k), 8'(k * 17));
        send_item(rc4_pkg::CMD_INIT, 8'hFF, 8'hFF);
        repeat (5) send_generate();
        send_item(rc4_pkg::CMD_REMIX, 8'h00, 8'h00);
        repeat (2) send_generate();
        wait_idle();
    endtask

    task automatic run_key_len(logic [rc4_pkg::APB_DW-1:0] len_value);
        write_key_len(len_value);
        send_schedule(rc4_pkg::CMD_INIT);
        repeat (6) send_generate();
        send_schedule(rc4_pkg::CMD_REMIX);
        repeat (3) send_generate();
        wait_idle();
    endtask

    task automatic test_key_lengths();
        run_key_len(32'd1);
        run_key_len(32'd0);             // zero length acts as one
        run_key_len(32'd300);           // saturates to the store depth
        run_key_len(32'd256);
        run_key_len(32'd511);
        run_key_len(32'hFFFF_FE05);     // only the low 9 bits count
        run_key_len((rc4_pkg::APB_DW)'(rc4_pkg::KEY_LEN_RST));
    endtask

    // receiver holds off while generates keep coming, so the input backs up
    task automatic test_backpressure();
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (40) send_generate();
        no_idle  = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int unsigned                r;
        logic [rc4_pkg::APB_DW-1:0] v;
        for (int ph = 0; ph < 3; ph++) begin
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = (rc4_pkg::APB_DW)'(rc4_pkg::KEY_DEPTH_DEF);
                2:       v = $urandom_range(257, 511);
                default: v = $urandom_range(1, 24);
            endcase
            if ($urandom_range(0, 3) == 0)
                v[rc4_pkg::APB_DW-1:rc4_pkg::KEY_LEN_W] =
                    (rc4_pkg::APB_DW - rc4_pkg::KEY_LEN_W)'($urandom);
            write_key_len(v);
            for (int k = 0; k < 32; k++) begin
                r = $urandom_range(0, 99);
                if (r < 55)      send_generate();
                else if (r < 85) send_item(rc4_pkg::CMD_LOAD, 8'($urandom), 8'($urandom));
                else if (r < 93) send_schedule(rc4_pkg::CMD_REMIX);
                else             send_schedule(rc4_pkg::CMD_INIT);
            end
            wait_idle();
        end
    endtask

    task automatic test_drain();
        int unsigned r;
        no_idle = 1'b1;
        for (int k = 0; k < 40; k++) begin
            r = $urandom_range(0, 99);
            if (r < 80)      send_generate();
            else if (r < 95) send_item(rc4_pkg::CMD_LOAD, 8'($urandom), 8'($urandom));
            else             send_schedule(rc4_pkg::CMD_REMIX);
        end
        wait_idle();
    endtask

    // receiver side: random stall bursts, one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (keystream_q.size() == 0) begin
                note_mismatch("unexpected keystream item", 32'd0, 32'(o_keystream_byte));
            end else begin
                want_byte = keystream_q.pop_front();
                if (o_keystream_byte !== want_byte)
                    note_mismatch("keystream_byte", 32'(want_byte), 32'(o_keystream_byte));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_key_lengths();
        test_backpressure();
        test_random_traffic();
        test_drain();
        if (mismatches == 0 && keystream_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
